FILE: hdl/spi_flash_erase_sequencer_core_assert.svh
// Assertion macros used by the checker file.
`ifndef SPI_FLASH_ERASE_SEQUENCER_CORE_ASSERT_SVH
`define SPI_FLASH_ERASE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SFES_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SFES_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/sfes_pkg.sv
package sfes_pkg;

    localparam int ADDR_BITS_DEF = 24;
    localparam int ADDR_W        = 24;
    localparam int LEN_W         = 25;
    localparam int ST_W          = 8;
    localparam int SUM_W         = LEN_W + 1;
    localparam int OP_W          = 8;
    localparam int BO_W          = 3;
    localparam int OUTC_W        = 2;

    localparam int IN_TDATA_W    = 64;
    localparam int OUT_TDATA_W   = 48;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 25;

    localparam logic [OP_W-1:0] OP_EWSR = 8'h50;
    localparam logic [OP_W-1:0] OP_WRSR = 8'h01;
    localparam logic [OP_W-1:0] OP_WREN = 8'h06;
    localparam logic [OP_W-1:0] OP_E4K  = 8'h20;
    localparam logic [OP_W-1:0] OP_E32K = 8'h52;
    localparam logic [OP_W-1:0] OP_E64K = 8'hd8;
    localparam logic [OP_W-1:0] OP_CHIP = 8'h60;
    localparam logic [OP_W-1:0] OP_RDSR = 8'h05;

    localparam int ST_BUSY_BIT = 0;

    localparam logic [LEN_W-1:0] SZ_64K = 25'h001_0000;
    localparam logic [LEN_W-1:0] SZ_32K = 25'h000_8000;
    localparam logic [LEN_W-1:0] SZ_4K  = 25'h000_1000;

    localparam logic [LEN_W-1:0] FLASH_BYTES_RST = 25'h040_0000;

    localparam logic [BO_W-1:0] BO_ONE  = 3'd1;
    localparam logic [BO_W-1:0] BO_TWO  = 3'd2;
    localparam logic [BO_W-1:0] BO_FOUR = 3'd4;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_STATUS = 1'b1;

    localparam logic [OUTC_W-1:0] OUTC_OK     = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_FAIL   = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_NOSIZE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_4K    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_32K   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_64K   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_CHIP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_BYTES = 3'd4;

    typedef struct packed {
        logic              allow_4k;
        logic              allow_32k;
        logic              allow_64k;
        logic              allow_chip;
        logic [LEN_W-1:0]  flash_bytes;
    } cfg_t;

    typedef struct packed {
        logic              found;
        logic [LEN_W-1:0]  piece_bytes;
        logic [OP_W-1:0]   opcode;
        logic              use_addr;
    } pick_t;

    typedef enum logic [1:0] {
        KIND_PIECE,
        KIND_POLL,
        KIND_END
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [OP_W-1:0]    erase_op;
        logic [ADDR_W-1:0]  erase_addr;
        logic [BO_W-1:0]    erase_bo;
        logic [OUTC_W-1:0]  outcome;
        logic [ST_W-1:0]    fail_st;
    } emit_load_t;

endpackage

FILE: hdl/spi_flash_erase_sequencer_core.sv
// Channel   Dir  Payload                                         Beats per item
// s_*       in   tuser command; tdata start, length, status      one
// m_*       out  tuser frame_valid; tdata frame fields; tlast    one to five
// cfg_*     in   register index and data, no read-back           one write
//
// An erase start or a clean status reply gives five beats (one piece) or one end beat;
// a busy reply gives one poll beat and a failing reply one end beat. The output stage
// presents one beat per cycle while m_tready is high; one-beat items run at one per cycle.
// A one-entry input register takes the next item while beats are still waiting.
// Reset clears the sequencer to idle and restores the default configuration.
// A stall on m_tready holds the current beat and backs up into the input register.
module spi_flash_erase_sequencer_core
#(
    parameter int ADDR_BITS = sfes_pkg::ADDR_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sfes_pkg::IN_TDATA_W-1:0]     s_tdata,  // start_address, erase_length,
                                                          // status_byte, pad
    input  logic                                s_tuser,  // command
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sfes_pkg::OUT_TDATA_W-1:0]    m_tdata,  // frame_opcode, frame_address,
                                                          // bytes_out, bytes_in, finished,
                                                          // outcome, failing_status, pad
    output logic                                m_tuser,  // frame_valid
    output logic                                m_tlast,
    input  logic                                cfg_wen,
    input  logic [sfes_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfes_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int LW = sfes_pkg::LEN_W;
    localparam int LEN_LO = sfes_pkg::ADDR_W;
    localparam int ST_LO  = sfes_pkg::ADDR_W + sfes_pkg::LEN_W;

    sfes_pkg::cfg_t         cfg;
    sfes_pkg::pick_t        pk;
    sfes_pkg::emit_load_t   ld;

    logic                           in_vld_reg;
    logic                           in_cmd_reg;
    logic [ADDR_BITS-1:0]           in_addr_reg;
    logic [LW-1:0]                  in_len_reg;
    logic [sfes_pkg::ST_W-1:0]      in_st_reg;

    logic                           phase_reg, phase_next;
    logic [ADDR_BITS-1:0]           cur_addr_reg;
    logic [LW-1:0]                  left_reg, piece_reg, piece_next;
    logic [LW-1:0]                  span_reg, span_next;
    logic [ADDR_BITS-1:0]           adv_addr_reg, adv_addr_next;
    logic [LW-1:0]                  adv_left_reg, adv_left_next;
    logic [LW-1:0]                  pmask, off, span_full;

    logic                           emit_can_load, emit_load;
    logic                           stray, exec_go, use_start, update_pos;
    logic [ADDR_BITS-1:0]           pa;
    logic [LW-1:0]                  pn;

    sfes_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sfes_pick #(.ADDR_BITS(ADDR_BITS)) u_pick
    (
        .addr (pa),
        .len  (pn),
        .cfg  (cfg),
        .pick (pk)
    );

    sfes_emit u_emit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (emit_load),
        .ld       (ld),
        .can_load (emit_can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assign s_tready = !in_vld_reg || exec_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_vld_reg <= 1'b1;
        else if (exec_go)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= s_tuser;
            in_addr_reg <= s_tdata[ADDR_BITS-1:0];
            in_len_reg  <= s_tdata[LEN_LO +: LW];
            in_st_reg   <= s_tdata[ST_LO +: sfes_pkg::ST_W];
        end
    end

    always_comb
    begin
        stray      = (in_cmd_reg == sfes_pkg::CMD_STATUS) && !phase_reg;
        exec_go    = in_vld_reg && (emit_can_load || stray);
        use_start  = (in_cmd_reg == sfes_pkg::CMD_START);
        pa         = use_start ? in_addr_reg : adv_addr_reg;
        pn         = use_start ? in_len_reg : adv_left_reg;

        emit_load     = 1'b0;
        update_pos    = 1'b0;
        phase_next    = phase_reg;
        piece_next    = piece_reg;
        ld.kind       = sfes_pkg::KIND_END;
        ld.erase_op   = pk.opcode;
        ld.erase_addr = pk.use_addr ? sfes_pkg::ADDR_W'(pa) : '0;
        ld.erase_bo   = pk.use_addr ? sfes_pkg::BO_FOUR : sfes_pkg::BO_ONE;
        ld.outcome    = sfes_pkg::OUTC_OK;
        ld.fail_st    = '0;

        if (exec_go && !stray)
        begin
            emit_load = 1'b1;
            if (!use_start && in_st_reg[sfes_pkg::ST_BUSY_BIT])
                ld.kind = sfes_pkg::KIND_POLL;
            else if (!use_start && (in_st_reg != '0))
            begin
                ld.outcome = sfes_pkg::OUTC_FAIL;
                ld.fail_st = in_st_reg;
                phase_next = 1'b0;
            end
            else
            begin
                update_pos = 1'b1;
                if (pn == '0)
                    phase_next = 1'b0;
                else if (!pk.found)
                begin
                    ld.outcome = sfes_pkg::OUTC_NOSIZE;
                    phase_next = 1'b0;
                end
                else
                begin
                    ld.kind    = sfes_pkg::KIND_PIECE;
                    phase_next = 1'b1;
                    piece_next = pk.piece_bytes;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= 1'b0;
            cur_addr_reg <= '0;
            left_reg     <= '0;
            piece_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            piece_reg <= piece_next;
            if (update_pos)
            begin
                cur_addr_reg <= pa;
                left_reg     <= pn;
            end
        end
    end

    // Advance for the next piece, worked out ahead over two stages; a clean status
    // cannot reach the sequencer before the five beats of the piece have drained.
    always_comb
    begin
        pmask         = piece_reg - LW'(1);
        off           = LW'(cur_addr_reg) & pmask;
        span_full     = piece_reg - off;
        span_next     = (span_full > left_reg) ? left_reg : span_full;
        adv_addr_next = cur_addr_reg + span_reg[ADDR_BITS-1:0];
        adv_left_next = left_reg - span_reg;
    end

    always_ff @(posedge clk)
    begin
        span_reg     <= span_next;
        adv_addr_reg <= adv_addr_next;
        adv_left_reg <= adv_left_next;
    end

endmodule

FILE: hdl/sfes_cfg.sv
module sfes_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [sfes_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfes_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output sfes_pkg::cfg_t                    cfg
);

    sfes_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.allow_4k    <= 1'b1;
            cfg_reg.allow_32k   <= 1'b1;
            cfg_reg.allow_64k   <= 1'b1;
            cfg_reg.allow_chip  <= 1'b1;
            cfg_reg.flash_bytes <= sfes_pkg::FLASH_BYTES_RST;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                sfes_pkg::REG_ALLOW_4K:    cfg_reg.allow_4k    <= cfg_wdata[0];
                sfes_pkg::REG_ALLOW_32K:   cfg_reg.allow_32k   <= cfg_wdata[0];
                sfes_pkg::REG_ALLOW_64K:   cfg_reg.allow_64k   <= cfg_wdata[0];
                sfes_pkg::REG_ALLOW_CHIP:  cfg_reg.allow_chip  <= cfg_wdata[0];
                sfes_pkg::REG_FLASH_BYTES:
                    cfg_reg.flash_bytes <= cfg_wdata[sfes_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/sfes_pick.sv
module sfes_pick
#(
    parameter int ADDR_BITS = sfes_pkg::ADDR_BITS_DEF
)
(
    input  logic [ADDR_BITS-1:0]          addr,
    input  logic [sfes_pkg::LEN_W-1:0]    len,
    input  sfes_pkg::cfg_t                cfg,
    output sfes_pkg::pick_t               pick
);

    localparam int SW = sfes_pkg::SUM_W;

    logic [SW-1:0] a_x, lim;
    logic [SW-1:0] o64, o32, o4, e64, e32;
    logic [SW-1:0] cur_o, cur_e;
    logic          take64, take32, take4, take_chip, have1, have2;
    logic [sfes_pkg::LEN_W-1:0] sz2, pb;

    always_comb
    begin
        a_x = SW'(addr);
        lim = a_x + SW'(len);

        o64 = a_x & ~SW'(sfes_pkg::SZ_64K - 25'd1);
        o32 = a_x & ~SW'(sfes_pkg::SZ_32K - 25'd1);
        o4  = a_x & ~SW'(sfes_pkg::SZ_4K - 25'd1);
        e64 = o64 + SW'(sfes_pkg::SZ_64K);
        e32 = o32 + SW'(sfes_pkg::SZ_32K);

        // A smaller size wins when the current block starts too low or runs past the range.
        take64 = cfg.allow_64k;
        take32 = cfg.allow_32k && (!take64 || (o64 < o32) || (e64 > lim));
        have1  = take64 || take32;
        cur_o  = take32 ? o32 : o64;
        cur_e  = take32 ? e32 : e64;
        take4  = cfg.allow_4k && (!have1 || (cur_o < o4) || (cur_e > lim));
        have2  = have1 || take4;

        if (take4)
            sz2 = sfes_pkg::SZ_4K;
        else if (take32)
            sz2 = sfes_pkg::SZ_32K;
        else if (take64)
            sz2 = sfes_pkg::SZ_64K;
        else
            sz2 = '0;

        take_chip = cfg.allow_chip && (!have2 || (len == cfg.flash_bytes));
        pb        = take_chip ? cfg.flash_bytes : sz2;

        pick.found       = (pb != '0);
        pick.piece_bytes = pb;
        pick.use_addr    = 1'b1;
        // Opcode follows the piece size, even when it came from the chip size.
        if (pb == sfes_pkg::SZ_64K)
            pick.opcode = sfes_pkg::OP_E64K;
        else if (pb == sfes_pkg::SZ_32K)
            pick.opcode = sfes_pkg::OP_E32K;
        else if (pb == sfes_pkg::SZ_4K)
            pick.opcode = sfes_pkg::OP_E4K;
        else
        begin
            pick.opcode   = sfes_pkg::OP_CHIP;
            pick.use_addr = 1'b0;
        end
    end

endmodule

FILE: hdl/sfes_emit.sv
module sfes_emit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  sfes_pkg::emit_load_t                ld,
    output logic                                can_load,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sfes_pkg::OUT_TDATA_W-1:0]    m_tdata,  // opcode, address, bytes_out,
                                                          // bytes_in, finished, outcome,
                                                          // failing_status, pad
    output logic                                m_tuser,  // frame_valid
    output logic                                m_tlast
);

    typedef enum logic [2:0] {
        B_EWSR,
        B_WRSR,
        B_WREN,
        B_ERASE,
        B_RDSR
    } beat_t;

    logic                               busy_reg;
    beat_t                              beat_reg;
    sfes_pkg::kind_t                    kind_reg;
    logic [sfes_pkg::OP_W-1:0]          op_reg;
    logic [sfes_pkg::ADDR_W-1:0]        addr_reg;
    logic [sfes_pkg::BO_W-1:0]          bo_reg;
    logic [sfes_pkg::OUTC_W-1:0]        outc_reg;
    logic [sfes_pkg::ST_W-1:0]          fs_reg;

    logic                               f_valid, f_fin, f_bi, is_last;
    logic [sfes_pkg::OP_W-1:0]          f_op;
    logic [sfes_pkg::ADDR_W-1:0]        f_addr;
    logic [sfes_pkg::BO_W-1:0]          f_bo;
    logic [sfes_pkg::OUTC_W-1:0]        f_outc;
    logic [sfes_pkg::ST_W-1:0]          f_fs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            beat_reg <= B_EWSR;
            kind_reg <= sfes_pkg::KIND_END;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            kind_reg <= ld.kind;
            beat_reg <= (ld.kind == sfes_pkg::KIND_PIECE) ? B_EWSR : B_RDSR;
        end
        else if (busy_reg && m_tready)
        begin
            if (is_last)
                busy_reg <= 1'b0;
            else
                beat_reg <= beat_t'(beat_reg + 3'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg   <= ld.erase_op;
            addr_reg <= ld.erase_addr;
            bo_reg   <= ld.erase_bo;
            outc_reg <= ld.outcome;
            fs_reg   <= ld.fail_st;
        end
    end

    always_comb
    begin
        f_valid = 1'b1;
        f_op    = '0;
        f_addr  = '0;
        f_bo    = sfes_pkg::BO_ONE;
        f_bi    = 1'b0;
        f_fin   = 1'b0;
        f_outc  = sfes_pkg::OUTC_OK;
        f_fs    = '0;
        is_last = 1'b1;
        case (kind_reg)
            sfes_pkg::KIND_PIECE:
            begin
                is_last = (beat_reg == B_RDSR);
                case (beat_reg)
                    B_EWSR:  f_op = sfes_pkg::OP_EWSR;
                    B_WRSR:
                    begin
                        f_op = sfes_pkg::OP_WRSR;
                        f_bo = sfes_pkg::BO_TWO;
                    end
                    B_WREN:  f_op = sfes_pkg::OP_WREN;
                    B_ERASE:
                    begin
                        f_op   = op_reg;
                        f_addr = addr_reg;
                        f_bo   = bo_reg;
                    end
                    default:
                    begin
                        f_op = sfes_pkg::OP_RDSR;
                        f_bi = 1'b1;
                    end
                endcase
            end
            sfes_pkg::KIND_POLL:
            begin
                f_op = sfes_pkg::OP_RDSR;
                f_bi = 1'b1;
            end
            default:
            begin
                f_valid = 1'b0;
                f_bo    = '0;
                f_fin   = 1'b1;
                f_outc  = outc_reg;
                f_fs    = fs_reg;
            end
        endcase
    end

    assign can_load = !busy_reg || (m_tready && is_last);
    assign m_tvalid = busy_reg;
    assign m_tuser  = f_valid;
    assign m_tlast  = is_last;
    assign m_tdata  = {1'b0, f_fs, f_outc, f_fin, f_bi, f_bo, f_addr, f_op};

endmodule

FILE: hdl/sfes_checker.sv
`include "spi_flash_erase_sequencer_core_assert.svh"

module sfes_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [sfes_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                m_tuser,
    input  logic                                m_tlast
);

    logic [sfes_pkg::OP_W-1:0]      c_op;
    logic                           c_bi;
    logic                           c_fin;
    logic [sfes_pkg::OUTC_W-1:0]    c_outc;
    logic [sfes_pkg::ST_W-1:0]      c_fs;

    assign c_op   = m_tdata[7:0];
    assign c_bi   = m_tdata[35];
    assign c_fin  = m_tdata[36];
    assign c_outc = m_tdata[38:37];
    assign c_fs   = m_tdata[46:39];

    `SFES_ASSERT_NXT(a_stall_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "output beat changed while stalled")

    `SFES_ASSERT_IMP(a_end_is_last, m_tvalid && !m_tuser, m_tlast && c_fin,
        "end beat not marked final")

    `SFES_ASSERT_IMP(a_frame_no_end, m_tvalid && m_tuser,
        !c_fin && (c_outc == sfes_pkg::OUTC_OK) && (c_fs == '0),
        "frame beat carries end status")

    `SFES_ASSERT_IMP(a_poll_last, m_tvalid && m_tuser && c_bi,
        m_tlast && (c_op == sfes_pkg::OP_RDSR),
        "status poll not last beat")

    `SFES_ASSERT_NXT(a_ewsr_then_wrsr,
        m_tvalid && m_tready && m_tuser && (c_op == sfes_pkg::OP_EWSR),
        m_tvalid && m_tuser && (c_op == sfes_pkg::OP_WRSR),
        "EWSR not followed by WRSR")

endmodule

bind spi_flash_erase_sequencer_core sfes_checker u_sfes_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
